### hw/rtl/wavhs_pkg.sv
// Package for the WAV header field scanner.
// Holds the transfer payload types, the status codes and the tag constants.
// No dependencies.
package wavhs_pkg;

  localparam logic [5:0]  MinHeaderBytes = 6'd44;

  // Tags as seen in the four-byte window, oldest byte in the top lane.
  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagData = 32'h6461_7461;

  // Bit positions in the found-tags vector.
  localparam int unsigned TagBitRiff = 0;
  localparam int unsigned TagBitWave = 1;
  localparam int unsigned TagBitData = 2;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusShort   = 2'd1,
    StatusMissing = 2'd2
  } wavhs_status_e;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       last_byte;
  } wavhs_in_t;

  typedef struct packed {
    wavhs_status_e status;
    logic [31:0]   riff_len;
    logic [15:0]   audio_format;
    logic [15:0]   channel_count;
    logic [31:0]   frame_rate;
    logic [15:0]   sample_width;
    logic [31:0]   payload_len;
  } wavhs_out_t;

endpackage

### hw/rtl/wavhs_scan.sv
// Scan state of the WAV header field scanner: byte window, tag match,
// field capture and the result formed on the final byte.
// Depends on wavhs_pkg.
module wavhs_scan (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  wavhs_pkg::wavhs_in_t   item_i,
  output wavhs_pkg::wavhs_out_t  result_o
);
  import wavhs_pkg::*;

  logic [23:0] recent_q, recent_d;
  logic [5:0]  seen_q, seen_d, seen_c;
  logic [2:0]  tags_q, tags_d, tags_c;
  logic [2:0]  riff_cnt_q, riff_cnt_d, riff_cnt_c;
  logic [4:0]  wave_cnt_q, wave_cnt_d, wave_cnt_c;
  logic [2:0]  data_cnt_q, data_cnt_d, data_cnt_c;
  logic [31:0] size_q, size_d, size_c;
  logic [15:0] fmt_q, fmt_d, fmt_c;
  logic [15:0] chan_q, chan_d, chan_c;
  logic [31:0] rate_q, rate_d, rate_c;
  logic [15:0] bits_q, bits_d, bits_c;
  logic [31:0] dsize_q, dsize_d, dsize_c;

  logic [31:0] window;
  logic [7:0]  b;
  logic [1:0]  riff_lane, data_lane;
  logic [4:0]  wave_off;

  assign b         = item_i.header_byte;
  assign window    = {recent_q, b};
  assign riff_lane = 2'(riff_cnt_q - 3'd1);
  assign data_lane = 2'(data_cnt_q - 3'd1);
  assign wave_off  = wave_cnt_q + 5'd3;  // byte offset from the WAVE tag start

  // Field capture for tags found on earlier bytes.
  always_comb begin
    seen_c     = (seen_q < MinHeaderBytes) ? seen_q + 6'd1 : seen_q;
    size_c     = size_q;
    dsize_c    = dsize_q;
    fmt_c      = fmt_q;
    chan_c     = chan_q;
    rate_c     = rate_q;
    bits_c     = bits_q;
    riff_cnt_c = riff_cnt_q;
    data_cnt_c = data_cnt_q;
    wave_cnt_c = wave_cnt_q;
    if (riff_cnt_q != 3'd0) begin
      size_c[{riff_lane, 3'b000} +: 8] = b;
      riff_cnt_c = (riff_cnt_q >= 3'd4) ? 3'd0 : riff_cnt_q + 3'd1;
    end
    if (data_cnt_q != 3'd0) begin
      dsize_c[{data_lane, 3'b000} +: 8] = b;
      data_cnt_c = (data_cnt_q >= 3'd4) ? 3'd0 : data_cnt_q + 3'd1;
    end
    if (wave_cnt_q != 5'd0) begin
      priority if (wave_off == 5'd12 || wave_off == 5'd13) begin
        fmt_c[{wave_off[0], 3'b000} +: 8] = b;
      end else if (wave_off == 5'd14 || wave_off == 5'd15) begin
        chan_c[{wave_off[0], 3'b000} +: 8] = b;
      end else if (wave_off >= 5'd16 && wave_off <= 5'd19) begin
        rate_c[{wave_off[1:0], 3'b000} +: 8] = b;
      end else if (wave_off == 5'd26 || wave_off == 5'd27) begin
        bits_c[{wave_off[0], 3'b000} +: 8] = b;
      end else begin
        // offsets between fields are skipped
      end
      wave_cnt_c = (wave_cnt_q >= 5'd24) ? 5'd0 : wave_cnt_q + 5'd1;
    end

    // First match of each tag only; a tag ending on the final byte is dropped.
    tags_c = tags_q;
    if (!item_i.last_byte) begin
      priority if (!tags_q[TagBitRiff] && window == TagRiff) begin
        tags_c[TagBitRiff] = 1'b1;
        riff_cnt_c         = 3'd1;
      end else if (!tags_q[TagBitWave] && window == TagWave) begin
        tags_c[TagBitWave] = 1'b1;
        wave_cnt_c         = 5'd1;
      end else if (!tags_q[TagBitData] && window == TagData) begin
        tags_c[TagBitData] = 1'b1;
        data_cnt_c         = 3'd1;
      end else begin
        // no new tag
      end
    end
  end

  // Final byte: the scan returns to its reset state.
  always_comb begin
    if (item_i.last_byte) begin
      recent_d   = '0;
      seen_d     = '0;
      tags_d     = '0;
      riff_cnt_d = '0;
      wave_cnt_d = '0;
      data_cnt_d = '0;
      size_d     = '0;
      fmt_d      = '0;
      chan_d     = '0;
      rate_d     = '0;
      bits_d     = '0;
      dsize_d    = '0;
    end else begin
      recent_d   = window[23:0];
      seen_d     = seen_c;
      tags_d     = tags_c;
      riff_cnt_d = riff_cnt_c;
      wave_cnt_d = wave_cnt_c;
      data_cnt_d = data_cnt_c;
      size_d     = size_c;
      fmt_d      = fmt_c;
      chan_d     = chan_c;
      rate_d     = rate_c;
      bits_d     = bits_c;
      dsize_d    = dsize_c;
    end
  end

  always_comb begin
    result_o = '0;
    priority if (seen_c < MinHeaderBytes) begin
      result_o.status = StatusShort;
    end else if (tags_c == 3'b111) begin
      result_o.status        = StatusOk;
      result_o.riff_len      = size_c;
      result_o.audio_format  = fmt_c;
      result_o.channel_count = chan_c;
      result_o.frame_rate    = rate_c;
      result_o.sample_width  = bits_c;
      result_o.payload_len   = dsize_c;
    end else begin
      result_o.status = StatusMissing;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q   <= '0;
      seen_q     <= '0;
      tags_q     <= '0;
      riff_cnt_q <= '0;
      wave_cnt_q <= '0;
      data_cnt_q <= '0;
      size_q     <= '0;
      fmt_q      <= '0;
      chan_q     <= '0;
      rate_q     <= '0;
      bits_q     <= '0;
      dsize_q    <= '0;
    end else if (step_i) begin
      recent_q   <= recent_d;
      seen_q     <= seen_d;
      tags_q     <= tags_d;
      riff_cnt_q <= riff_cnt_d;
      wave_cnt_q <= wave_cnt_d;
      data_cnt_q <= data_cnt_d;
      size_q     <= size_d;
      fmt_q      <= fmt_d;
      chan_q     <= chan_d;
      rate_q     <= rate_d;
      bits_q     <= bits_d;
      dsize_q    <= dsize_d;
    end
  end

endmodule

### hw/rtl/wav_header_field_scanner.sv
// WAV header field scanner, top level.
// Header bytes come in on the in channel, one byte per transfer, with
// last_byte set on the final byte of a header. The block looks for the
// RIFF, WAVE and data tags and captures the file size, format, channel
// count, sample rate, bits per sample and data size behind them.
// The final byte produces exactly one result transfer on the out channel:
// status ok with the fields, or status short / missing with zero fields.
// Other bytes produce nothing.
// Throughput: one byte per cycle unless in_stall_o is raised. A byte sits
// in the input register while the scan state updates; the result register
// loads on that step, so a result is shown once the final byte's step is
// taken and holds until the receiver takes it.
// While a result waits under out_stall_i, non-final bytes keep flowing;
// only a following final byte stalls the input until the result leaves.
// Reset clears the scan state and both pipeline valid bits.
// Depends on wavhs_pkg and wavhs_scan.
module wav_header_field_scanner (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  wavhs_pkg::wavhs_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output wavhs_pkg::wavhs_out_t  out_data_o
);
  import wavhs_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  wavhs_in_t  s1_item_q;
  logic       out_valid_q, out_valid_d;
  wavhs_out_t out_q;
  wavhs_out_t result;
  logic       out_free;
  logic       advance;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && (!s1_item_q.last_byte || out_free);
  assign in_stall_o = s1_valid_q && !advance;

  wavhs_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_item_q),
    .result_o (result)
  );

  always_comb begin
    s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;
    priority if (advance && s1_item_q.last_byte) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_data_i;
    end
    if (advance && s1_item_q.last_byte) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/wavhs_checker.sv
// Port-level checks for the WAV header field scanner, bound to the top level.
// Depends on wavhs_pkg and wav_header_field_scanner.
module wavhs_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_o,
  input  logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  wavhs_pkg::wavhs_out_t  out_data_o
);
  import wavhs_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StatusOk ||
                     out_data_o.status == StatusShort ||
                     out_data_o.status == StatusMissing))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StatusOk |->
      out_data_o.riff_len == '0 && out_data_o.audio_format == '0 &&
      out_data_o.channel_count == '0 && out_data_o.frame_rate == '0 &&
      out_data_o.sample_width == '0 && out_data_o.payload_len == '0)
    else $error("failed result carries nonzero fields");

  // An idle pipe never stalls the sender.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && !out_valid_o |=> !in_stall_o || $past(in_valid_i, 2))
    else $error("input stalled with nothing in flight");

  // Reset leaves both handshake outputs quiet.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("activity during reset");

endmodule

bind wav_header_field_scanner wavhs_checker u_wavhs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### tb/wavhs_tb_pkg.sv
// Scoreboard class for the WAV header field scanner testbench.
// Tracks the scan state byte by byte and checks each result transfer.
// Depends on wavhs_pkg.
package wavhs_tb_pkg;
  import wavhs_pkg::*;

  class wavhs_header_scoreboard;
    wavhs_out_t  header_reports_q[$];
    logic [23:0] recent;
    logic [5:0]  seen;
    logic [2:0]  found;
    int unsigned riff_pos, wave_pos, data_pos;
    logic [31:0] size_w, rate_w, payload_w;
    logic [15:0] format_w, chan_w, bits_w;
    int unsigned mismatches;
    int unsigned checked;
    int unsigned status_count[4];

    function new();
      clear_scan();
      mismatches = 0;
      checked    = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void clear_scan();
      recent    = '0;
      seen      = '0;
      found     = '0;
      riff_pos  = 0;
      wave_pos  = 0;
      data_pos  = 0;
      size_w    = '0;
      rate_w    = '0;
      payload_w = '0;
      format_w  = '0;
      chan_w    = '0;
      bits_w    = '0;
    endfunction

    function int unsigned pending();
      return header_reports_q.size();
    endfunction

    function string show(wavhs_out_t r);
      return $sformatf("status=%0d size=%h fmt=%h ch=%h rate=%h bits=%h data=%h",
                       r.status, r.riff_len, r.audio_format, r.channel_count,
                       r.frame_rate, r.sample_width, r.payload_len);
    endfunction

    // Advance the scan by one accepted byte; a final byte queues a report.
    function void scan_byte(wavhs_in_t item);
      logic [31:0] window;
      logic [7:0]  b;
      int unsigned off;
      wavhs_out_t  report;
      b      = item.header_byte;
      window = {recent, b};
      if (seen < MinHeaderBytes) seen = seen + 6'd1;

      if (riff_pos != 0) begin
        size_w[8*(riff_pos-1) +: 8] = b;
        riff_pos = (riff_pos >= 4) ? 0 : riff_pos + 1;
      end
      if (data_pos != 0) begin
        payload_w[8*(data_pos-1) +: 8] = b;
        data_pos = (data_pos >= 4) ? 0 : data_pos + 1;
      end
      if (wave_pos != 0) begin
        off = wave_pos + 3;  // offset from the first byte of the WAVE tag
        if (off == 12 || off == 13) format_w[8*(off-12) +: 8] = b;
        else if (off == 14 || off == 15) chan_w[8*(off-14) +: 8] = b;
        else if (off >= 16 && off <= 19) rate_w[8*(off-16) +: 8] = b;
        else if (off == 26 || off == 27) bits_w[8*(off-26) +: 8] = b;
        wave_pos = (wave_pos >= 24) ? 0 : wave_pos + 1;
      end

      // a tag completed by the final byte is ignored
      if (!item.last_byte) begin
        if (!found[TagBitRiff] && window == TagRiff) begin
          found[TagBitRiff] = 1'b1;
          riff_pos = 1;
        end else if (!found[TagBitWave] && window == TagWave) begin
          found[TagBitWave] = 1'b1;
          wave_pos = 1;
        end else if (!found[TagBitData] && window == TagData) begin
          found[TagBitData] = 1'b1;
          data_pos = 1;
        end
      end
      recent = window[23:0];

      if (item.last_byte) begin
        report = '0;
        if (seen < MinHeaderBytes) report.status = StatusShort;
        else if (found == 3'b111) report.status = StatusOk;
        else report.status = StatusMissing;
        if (report.status == StatusOk) begin
          report.riff_len      = size_w;
          report.audio_format  = format_w;
          report.channel_count = chan_w;
          report.frame_rate    = rate_w;
          report.sample_width  = bits_w;
          report.payload_len   = payload_w;
        end
        header_reports_q.push_back(report);
        clear_scan();
      end
    endfunction

    function void check_result(wavhs_out_t got);
      wavhs_out_t want;
      string      bad;
      checked++;
      if (header_reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with nothing outstanding: %s", show(got));
        return;
      end
      want = header_reports_q.pop_front();
      bad  = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.riff_len !== want.riff_len) bad = {bad, " riff_len"};
      if (got.audio_format !== want.audio_format) bad = {bad, " audio_format"};
      if (got.channel_count !== want.channel_count) bad = {bad, " channel_count"};
      if (got.frame_rate !== want.frame_rate) bad = {bad, " frame_rate"};
      if (got.sample_width !== want.sample_width) bad = {bad, " sample_width"};
      if (got.payload_len !== want.payload_len) bad = {bad, " payload_len"};
      status_count[int'(want.status)]++;
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d wrong in%s", checked, bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

### tb/wav_header_field_scanner_tb.sv
// Testbench top for wav_header_field_scanner.
// Streams directed and random RIFF/WAV headers under varied handshake pacing
// and checks every result against wavhs_tb_pkg's scoreboard; needs wavhs_pkg.
module wav_header_field_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wavhs_pkg::*;
  import wavhs_tb_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned ByteTarget = 2000;
  localparam logic [31:0] TagFmt     = 32'h666D_7420;  // "fmt "
  localparam logic [31:0] TagList    = 32'h4C49_5354;  // "LIST"

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  wavhs_in_t  in_data   = '0;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  wavhs_out_t out_data_o;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycles        = 0;
  int unsigned bytes_sent    = 0;
  int unsigned headers_sent  = 0;
  logic [7:0]  header_q[$];

  wavhs_header_scoreboard sb;

  wav_header_field_scanner uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Outputs are stable at the falling edge; a transfer there completes at the next rise.
  always @(negedge clk) begin
    if (rst_n && out_valid_o && !out_stall) sb.check_result(out_data_o);
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic void push_word(input logic [31:0] w, input int unsigned n);
    for (int i = 0; i < n; i++) header_q.push_back(w[8*i +: 8]);
  endfunction

  function automatic void push_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) header_q.push_back(tag[8*i +: 8]);
  endfunction

  function automatic void push_noise(input int unsigned n);
    repeat (n) header_q.push_back(8'($urandom_range(255)));
  endfunction

  // RIFF, size, WAVE and the fmt chunk: 36 bytes
  function automatic void push_wav_front();
    push_tag(TagRiff);
    push_word(pick_word(), 4);
    push_tag(TagWave);
    push_tag(TagFmt);
    push_word(32'd16, 4);
    push_word(pick_word(), 2);
    push_word(pick_word(), 2);
    push_word(pick_word(), 4);
    push_word(pick_word(), 4);
    push_word(pick_word(), 2);
    push_word(pick_word(), 2);
  endfunction

  function automatic void push_wav_header();
    push_wav_front();
    push_tag(TagData);
    push_word(pick_word(), 4);
  endfunction

  function automatic void build_header();
    int unsigned roll;
    int unsigned cut;
    int unsigned idx;
    roll = $urandom_range(99);
    header_q.delete();
    if (roll < 40) begin
      if ($urandom_range(1)) push_noise($urandom_range(6, 1));
      push_wav_header();
      if ($urandom_range(1)) push_noise($urandom_range(8, 1));
    end else if (roll < 50) begin
      // extra chunk between fmt and data
      push_wav_front();
      push_tag(TagList);
      push_word(32'd8, 4);
      push_noise($urandom_range(12));
      push_tag(TagData);
      push_word(pick_word(), 4);
    end else if (roll < 60) begin
      // one tag damaged by a single bit
      push_wav_header();
      case ($urandom_range(2))
        0:       idx = $urandom_range(3);
        1:       idx = 8 + $urandom_range(3);
        default: idx = 36 + $urandom_range(3);
      endcase
      header_q[idx] = header_q[idx] ^ (8'h01 << $urandom_range(7));
    end else if (roll < 70) begin
      push_wav_header();
      cut = $urandom_range(43, 1);
      while (header_q.size() > cut) void'(header_q.pop_back());
    end else if (roll < 78) begin
      // second copy of every tag, which must be ignored
      push_wav_header();
      push_wav_header();
      if ($urandom_range(1)) push_noise($urandom_range(5, 1));
    end else if (roll < 86) begin
      // data tag right at the end, ending on the final byte or up to three bytes before
      push_wav_front();
      push_noise($urandom_range(10, 4));
      push_tag(TagData);
      push_noise($urandom_range(3));
    end else if (roll < 93) begin
      push_noise($urandom_range(90, 1));
    end else begin
      // WAVE late so that its fields arrive only in part, never the bits per sample
      push_noise($urandom_range(40, 30));
      push_tag(TagRiff);
      push_word(pick_word(), 4);
      push_tag(TagData);
      push_word(pick_word(), 4);
      push_tag(TagWave);
      push_noise($urandom_range(20, 1));
    end
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    wavhs_in_t item;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.header_byte = value;
    item.last_byte   = is_last;
    in_valid <= 1'b1;
    in_data  <= item;
    @(negedge clk);
    while (in_stall_o) @(negedge clk);
    sb.scan_byte(item);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_header();
    for (int i = 0; i < header_q.size(); i++) send_byte(header_q[i], i == header_q.size() - 1);
    headers_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone extreme bytes, a tag ending on the final byte, short headers with tags
    header_q = {8'h00};
    send_header();
    header_q = {8'hFF};
    send_header();
    header_q.delete();
    push_tag(TagRiff);
    send_header();
    header_q.delete();
    push_tag(TagRiff);
    header_q.push_back(8'hFF);
    header_q.push_back(8'hFF);
    header_q.push_back(8'h00);
    header_q.push_back(8'h80);
    send_header();
    header_q.delete();
    push_tag(TagWave);
    header_q.push_back(8'h00);
    header_q.push_back(8'hFF);
    send_header();
    header_q.delete();
    push_tag(TagData);
    header_q.push_back(8'h7F);
    send_header();
    wait_for_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      while (bytes_sent < (phase + 1) * ByteTarget / 4) begin
        build_header();
        send_header();
        if ($urandom_range(9) == 0) wait_for_results();
      end
      wait_for_results();
    end

    stall_pct = 0;
    wait_for_results();
    repeat (8) @(posedge clk);

    $display("Scanned %0d headers (%0d bytes) under four pacing phases in %0d cycles.",
             headers_sent, bytes_sent, cycles);
    $display("Results checked: %0d (ok %0d, short %0d, missing %0d), mismatches %0d.",
             sb.checked, sb.status_count[StatusOk], sb.status_count[StatusShort],
             sb.status_count[StatusMissing], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
